FILE: src/assert_macros.svh
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/lppd_pkg.sv
// Types and constants for the length-prefixed packet deframer.
package lppd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HDR_WORDS = 4;
  localparam int unsigned HDR_BYTES = HDR_WORDS * (WORD_W / BYTE_W);
  localparam int unsigned CNT_W     = $clog2(HDR_BYTES + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  hdr_cnt_t;
  typedef logic [1:0]        status_t;

  // Header word slots, in stream order.
  localparam int unsigned W_SIG  = 0;
  localparam int unsigned W_FLAG = 1;
  localparam int unsigned W_ID   = 2;
  localparam int unsigned W_LEN  = 3;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_BAD_SIG   = 2'd1;
  localparam status_t STATUS_SHORT_LEN = 2'd2;

endpackage

FILE: src/lppd_channels.sv
// Handshake channel interfaces: input bytes, results and configuration.
interface lppd_byte_if import lppd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lppd_result_if import lppd_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   packet_flag;
  word_t   packet_id;
  word_t   packet_length;
  byte_t   body_byte;
  logic    has_byte;
  logic    last;
  status_t status;

  modport source (output valid, output packet_flag, output packet_id, output packet_length,
                  output body_byte, output has_byte, output last, output status,
                  input ready);
  modport sink   (input valid, input packet_flag, input packet_id, input packet_length,
                  input body_byte, input has_byte, input last, input status,
                  output ready);
endinterface

interface lppd_cfg_if import lppd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t magic_signature;

  modport source (output valid, output magic_signature, input ready);
  modport sink   (input valid, input magic_signature, output ready);
endinterface

FILE: src/length_prefixed_packet_deframer.sv
// Length-prefixed packet deframer top level.
//
//  channel | dir | beat carries
//  --------+-----+------------------------------------------------------------
//  in_i    | in  | data_byte: next byte of the received stream
//  out_o   | out | flag, id, length, body_byte, has_byte, last, status
//  cfg_i   | in  | magic_signature: expected first header word
//
// One byte a cycle: each beat is decoded by the header/body logic and any
// result lands in the output register at the same edge.
// in_i stalls only while a result sits in out_o and out_o.ready is low;
// once halted after an error the block sinks every byte without a stall.
// cfg_i is always ready. Asynchronous active-low reset clears the header
// count, the body count, the halt flag, the magic register and out_o.valid.
`include "assert_macros.svh"

module length_prefixed_packet_deframer import lppd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lppd_byte_if.sink          in_i,
  lppd_result_if.source      out_o,
  lppd_cfg_if.sink           cfg_i
);

  // Control state.
  hdr_cnt_t hdr_cnt_q, hdr_cnt_d;
  word_t    body_rem_q, body_rem_d;
  logic     halted_q, halted_d;
  word_t    magic_q;
  logic     out_valid_q, out_valid_d;

  // Header words, shifted in big-endian.
  word_t    hdr_q [HDR_WORDS];
  word_t    hdr_d [HDR_WORDS];

  // Result register payload.
  word_t    flag_q, id_q, len_q;
  byte_t    byte_q;
  logic     has_q, last_q;
  status_t  status_q;

  // Result computed for this beat.
  logic     res_load;
  byte_t    res_byte;
  logic     res_has, res_last;
  status_t  res_status;

  logic     in_fire;
  logic     in_body;
  logic     [1:0] word_sel;
  word_t    len_word;

  assign cfg_i.ready = 1'b1;

  // Take a byte whenever the result register is free or draining; drop
  // bytes freely once halted.
  assign in_i.ready = halted_q | ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;
  assign in_body    = hdr_cnt_q[CNT_W-1];
  assign word_sel   = hdr_cnt_q[3:2];
  assign len_word   = {hdr_q[W_LEN][WORD_W-BYTE_W-1:0], in_i.data_byte};

  always_comb begin
    hdr_d      = hdr_q;
    hdr_cnt_d  = hdr_cnt_q;
    body_rem_d = body_rem_q;
    halted_d   = halted_q;
    res_load   = 1'b0;
    res_byte   = '0;
    res_has    = 1'b0;
    res_last   = 1'b1;
    res_status = STATUS_OK;

    if (in_fire && !halted_q) begin
      if (!in_body) begin
        // Header byte: shift it into its word.
        hdr_d[word_sel] = {hdr_q[word_sel][WORD_W-BYTE_W-1:0], in_i.data_byte};
        hdr_cnt_d       = hdr_cnt_q + hdr_cnt_t'(1);
        if (hdr_cnt_q == hdr_cnt_t'(HDR_BYTES - 1)) begin
          // Header complete: signature first, then length.
          if (hdr_q[W_SIG] != magic_q) begin
            halted_d   = 1'b1;
            res_load   = 1'b1;
            res_status = STATUS_BAD_SIG;
          end else if (len_word < word_t'(HDR_BYTES)) begin
            halted_d   = 1'b1;
            res_load   = 1'b1;
            res_status = STATUS_SHORT_LEN;
          end else begin
            body_rem_d = len_word - word_t'(HDR_BYTES);
            if (len_word == word_t'(HDR_BYTES)) begin
              // Empty body: close the packet right away.
              hdr_cnt_d = '0;
              res_load  = 1'b1;
            end
          end
        end
      end else begin
        // Body byte: pass it out, mark the final one.
        body_rem_d = body_rem_q - word_t'(1);
        res_load   = 1'b1;
        res_byte   = in_i.data_byte;
        res_has    = 1'b1;
        res_last   = (body_rem_q == word_t'(1));
        if (res_last) begin
          hdr_cnt_d = '0;
        end
      end
    end

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      body_rem_q  <= '0;
      halted_q    <= 1'b0;
      magic_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_cnt_q   <= hdr_cnt_d;
      body_rem_q  <= body_rem_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        magic_q <= cfg_i.magic_signature;
      end
    end
  end

  // Header words and result payload: no reset, loaded before first use.
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (res_load) begin
      flag_q   <= hdr_d[W_FLAG];
      id_q     <= hdr_d[W_ID];
      len_q    <= hdr_d[W_LEN];
      byte_q   <= res_byte;
      has_q    <= res_has;
      last_q   <= res_last;
      status_q <= res_status;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.packet_flag   = flag_q;
  assign out_o.packet_id     = id_q;
  assign out_o.packet_length = len_q;
  assign out_o.body_byte     = byte_q;
  assign out_o.has_byte      = has_q;
  assign out_o.last          = last_q;
  assign out_o.status        = status_q;

  // Header count never runs past a full header.
  `ASSERT_ALWAYS(a_hdr_cnt_range, hdr_cnt_q <= hdr_cnt_t'(HDR_BYTES), "header count overflow")
  // An error halt is sticky until reset.
  `ASSERT_CLK(a_halt_sticky, halted_q |=> halted_q, "halt flag cleared without reset")
  // A live body phase always has bytes left to pass.
  `ASSERT_CLK(a_body_nonzero, (in_body && !halted_q) |-> (body_rem_q != '0), "body phase with no bytes left")

endmodule
